// File: sv/jsf_pkg.sv
// ----------------------------------------------------------------------------
// jsf_pkg
// Shared types and constants for the JSON object span finder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsf_pkg;

  // Buffer offsets: positions saturate at 2**OFS_W bytes.
  localparam int OFS_W   = 24;
  localparam int POS_W   = OFS_W + 1;
  localparam int DEPTH_W = 16;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH = {DEPTH_W{1'b1}};

  localparam logic [7:0] BYTE_OPEN   = 8'h7B;
  localparam logic [7:0] BYTE_CLOSE  = 8'h7D;
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    PH_SEARCH    = 2'd0,
    PH_INSIDE    = 2'd1,
    PH_FOUND     = 2'd2,
    PH_ABANDONED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_SEARCH    = 2'd0,
    ST_INSIDE    = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    phase_t             phase;
    logic               prev_open;
    logic               in_string;
    logic               esc_pending;
    logic [DEPTH_W-1:0] depth;
    logic [POS_W-1:0]   pos;
    logic [OFS_W-1:0]   obj_start;
    logic [POS_W-1:0]   obj_end;
    logic               overflow;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:       PH_SEARCH,
    prev_open:   1'b0,
    in_string:   1'b0,
    esc_pending: 1'b0,
    depth:       '0,
    pos:         '0,
    obj_start:   '0,
    obj_end:     '0,
    overflow:    1'b0
  };

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] start_offset;
    logic [POS_W-1:0] end_offset;
    logic             depth_overflow;
  } scan_result_t;

endpackage

`default_nettype wire

// File: sv/jsf_step.sv
// ----------------------------------------------------------------------------
// jsf_step
// One-byte scan step: next scanner state and the result for that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jsf_step import jsf_pkg::*; (
  input  scan_state_t  cur,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output scan_state_t  state_next,
  output scan_result_t result
);

  scan_state_t upd;
  status_t     st;

  // state update for this byte (before end-of-buffer reset)
  always_comb begin
    upd = cur;
    if (!cur.pos[POS_W-1]) begin
      unique case (cur.phase)
        PH_SEARCH: begin
          if (cur.prev_open && data_byte == BYTE_QUOTE) begin
            if (cur.pos == POS_W'(1)) begin
              upd.phase = PH_ABANDONED;
            end else begin
              upd.obj_start   = cur.pos[OFS_W-1:0] - OFS_W'(1);
              upd.depth       = DEPTH_W'(1);
              upd.in_string   = 1'b1;
              upd.esc_pending = 1'b0;
              upd.phase       = PH_INSIDE;
            end
          end
          upd.prev_open = (data_byte == BYTE_OPEN);
        end
        PH_INSIDE: begin
          if (cur.in_string) begin
            if (cur.esc_pending) begin
              upd.esc_pending = 1'b0;
            end else if (data_byte == BYTE_BSLASH) begin
              upd.esc_pending = 1'b1;
            end else if (data_byte == BYTE_QUOTE) begin
              upd.in_string = 1'b0;
            end
          end else if (data_byte == BYTE_QUOTE) begin
            upd.in_string = 1'b1;
          end else if (data_byte == BYTE_OPEN) begin
            if (cur.depth == MAX_DEPTH) begin
              upd.overflow = 1'b1;
            end else begin
              upd.depth = cur.depth + DEPTH_W'(1);
            end
          end else if (data_byte == BYTE_CLOSE) begin
            // closing brace that reaches depth zero ends the object
            if (cur.depth <= DEPTH_W'(1)) begin
              upd.depth   = '0;
              upd.obj_end = cur.pos + POS_W'(1);
              upd.phase   = PH_FOUND;
            end else begin
              upd.depth = cur.depth - DEPTH_W'(1);
            end
          end
        end
        PH_FOUND, PH_ABANDONED: begin
        end
        default: begin
        end
      endcase
      upd.pos = cur.pos + POS_W'(1);
    end
  end

  always_comb begin
    state_next = last_byte ? SCAN_RESET : upd;
  end

  // result for this byte
  always_comb begin
    unique case (upd.phase)
      PH_SEARCH:    st = ST_SEARCH;
      PH_INSIDE:    st = ST_INSIDE;
      PH_FOUND:     st = ST_FOUND;
      PH_ABANDONED: st = ST_SEARCH;
      default:      st = ST_SEARCH;
    endcase
    if (last_byte && upd.phase != PH_FOUND) begin
      st = ST_NOT_FOUND;
    end
    result.status         = st;
    result.start_offset   = (st == ST_INSIDE || st == ST_FOUND) ? upd.obj_start : '0;
    result.end_offset     = (st == ST_FOUND) ? upd.obj_end : '0;
    result.depth_overflow = upd.overflow;
  end

endmodule

`default_nettype wire

// File: sv/json_object_span_finder_unit.sv
// ----------------------------------------------------------------------------
// json_object_span_finder_unit
// Byte-stream scanner that locates the first JSON object in a buffer.
// ----------------------------------------------------------------------------
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+--------------------
//   in      | data_byte[7:0], last_byte                 | in_valid / in_stall
//   out     | status[1:0], start_offset[23:0],          | out_valid / out_stall
//           | end_offset[24:0], depth_overflow          |
//
// One byte per cycle while in_stall is low, one registered result per byte.
// The scan-state register loops through jsf_step, out_valid through in_stall.
// in_stall is raised only while the output register holds a result that the
// sink is stalling; a result taken in the same cycle frees the slot.
// Synchronous active-high reset clears the scan state and the output valid.
// A byte flagged last_byte reports and then returns the scanner to reset.
//
`default_nettype none

module json_object_span_finder_unit import jsf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // input transaction
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  // result transaction
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [OFS_W-1:0]        start_offset,
  output logic [POS_W-1:0]        end_offset,
  output logic                    depth_overflow
);

  scan_state_t  scan;
  scan_state_t  scan_next;
  scan_result_t step_result;
  scan_result_t result;
  logic         in_take;

  // Output register is the only buffer: stall input only while it is held.
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  jsf_step u_step (
    .cur        (scan),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .state_next (scan_next),
    .result     (step_result)
  );

  // scan state: advances once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (in_take) begin
      scan <= scan_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      result <= step_result;
    end
  end

  assign status         = result.status;
  assign start_offset   = result.start_offset;
  assign end_offset     = result.end_offset;
  assign depth_overflow = result.depth_overflow;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A found object always has its depth back at zero.
  a_found_depth_zero: assert property (@(posedge clk) disable iff (rst)
    scan.phase == PH_FOUND |-> scan.depth == '0)
    else $error("found phase with nonzero depth");

  // While inside the object the depth never reaches zero.
  a_inside_depth: assert property (@(posedge clk) disable iff (rst)
    scan.phase == PH_INSIDE |-> scan.depth != '0)
    else $error("inside phase with zero depth");

  // The end of a found span lies past its start.
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == ST_FOUND |->
      result.end_offset > {1'b0, result.start_offset})
    else $error("found span end not past start");

  // A last byte returns the scanner to the start of a buffer.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_take && last_byte |=> scan.phase == PH_SEARCH && scan.pos == '0)
    else $error("scanner not reset after last byte");

endmodule

`default_nettype wire

// File: tb/json_object_span_finder_unit_test.sv
// ----------------------------------------------------------------------------
// json_object_span_finder_unit_test
// Self-checking bench for the JSON object span finder. Byte buffers go in
// through the valid/stall input channel. A scan model inside the bench
// predicts every span report, and each report is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_span_finder_unit_test;
  import jsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // 20 ms is far past the slowest legal run with a 20 ns clock period.
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 4;

  // Bytes at or past this position change no scan state.
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(1) << OFS_W;

  // --------------------------------------------------------------------------
  // DUT connections. Every input has a known value from time zero.
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic [OFS_W-1:0]   start_offset;
  logic [POS_W-1:0]   end_offset;
  logic               depth_overflow;

  json_object_span_finder_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .start_offset   (start_offset),
    .end_offset     (end_offset),
    .depth_overflow (depth_overflow)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int unsigned  send_idle_pct = 0;  // chance of a gap before each byte
  int unsigned  recv_idle_pct = 0;  // chance of stall on each cycle
  int unsigned  sent_items    = 0;
  int unsigned  err_count     = 0;

  scan_result_t span_reports_q[$];  // predicted reports, oldest first
  logic [7:0]   frame_q[$];         // bytes of the buffer being built

  // Scan model state, one buffer at a time.
  phase_t             mdl_phase;
  logic               mdl_after_open;
  logic               mdl_in_str;
  logic               mdl_esc;
  logic [DEPTH_W-1:0] mdl_depth;
  logic [POS_W-1:0]   mdl_pos;
  logic [OFS_W-1:0]   mdl_start;
  logic [POS_W-1:0]   mdl_end;
  logic               mdl_ovf;

  function automatic void clear_scan();
    mdl_phase      = PH_SEARCH;
    mdl_after_open = 1'b0;
    mdl_in_str     = 1'b0;
    mdl_esc        = 1'b0;
    mdl_depth      = '0;
    mdl_pos        = '0;
    mdl_start      = '0;
    mdl_end        = '0;
    mdl_ovf        = 1'b0;
  endfunction

  // Advance the scan model by one byte and return the report it gives.
  function automatic scan_result_t scan_byte(logic [7:0] c, logic lst);
    scan_result_t rpt;
    status_t      st;
    if (mdl_pos < POS_LIMIT) begin
      case (mdl_phase)
        PH_SEARCH: begin
          // object opens at '{' directly followed by a quote
          if (mdl_after_open && c == BYTE_QUOTE) begin
            if (mdl_pos == 1) begin
              // candidate at offset zero: give up on this buffer
              mdl_phase = PH_ABANDONED;
            end else begin
              mdl_start  = OFS_W'(mdl_pos - 1);
              mdl_depth  = DEPTH_W'(1);
              mdl_in_str = 1'b1;
              mdl_esc    = 1'b0;
              mdl_phase  = PH_INSIDE;
            end
          end
          mdl_after_open = (c == BYTE_OPEN);
        end
        PH_INSIDE: begin
          if (mdl_in_str) begin
            if (mdl_esc) mdl_esc = 1'b0;
            else if (c == BYTE_BSLASH) mdl_esc = 1'b1;
            else if (c == BYTE_QUOTE) mdl_in_str = 1'b0;
          end else if (c == BYTE_QUOTE) begin
            mdl_in_str = 1'b1;
          end else if (c == BYTE_OPEN) begin
            // saturate instead of wrapping
            if (mdl_depth == MAX_DEPTH) mdl_ovf = 1'b1;
            else mdl_depth++;
          end else if (c == BYTE_CLOSE) begin
            if (mdl_depth != 0) mdl_depth--;
            if (mdl_depth == 0) begin
              mdl_end   = mdl_pos + POS_W'(1);
              mdl_phase = PH_FOUND;
            end
          end
        end
        default: ;
      endcase
      mdl_pos++;
    end

    case (mdl_phase)
      PH_INSIDE: st = ST_INSIDE;
      PH_FOUND:  st = ST_FOUND;
      default:   st = ST_SEARCH;
    endcase
    if (lst && mdl_phase != PH_FOUND) st = ST_NOT_FOUND;

    rpt.status         = st;
    rpt.start_offset   = (st == ST_INSIDE || st == ST_FOUND) ? mdl_start : '0;
    rpt.end_offset     = (st == ST_FOUND) ? mdl_end : '0;
    rpt.depth_overflow = mdl_ovf;
    if (lst) clear_scan();
    return rpt;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: check each accepted report against the oldest prediction,
  // then pick the stall for the next cycle. Values read here are the ones
  // the DUT saw at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    scan_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (span_reports_q.size() == 0) begin
        $error("unexpected report transaction: status %0d", status);
        err_count++;
      end else begin
        want = span_reports_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          err_count++;
        end
        if (start_offset !== want.start_offset) begin
          $error("start_offset: expected %0d, actual %0d",
                 want.start_offset, start_offset);
          err_count++;
        end
        if (end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, actual %0d",
                 want.end_offset, end_offset);
          err_count++;
        end
        if (depth_overflow !== want.depth_overflow) begin
          $error("depth_overflow: expected %0d, actual %0d",
                 want.depth_overflow, depth_overflow);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // One byte transaction: optional gap, then hold until accepted.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (in_stall);
    span_reports_q.push_back(scan_byte(b, lst));
    sent_items++;
  endtask

  // Send the built buffer, flagging its final byte, and empty it.
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  function automatic void push_text(string s);
    foreach (s[i]) frame_q.push_back(s[i]);
  endfunction

  // Noise with the structural bytes made common.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return BYTE_OPEN;
      1:       return BYTE_CLOSE;
      2:       return BYTE_QUOTE;
      3:       return BYTE_BSLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Object with random content; cut short when truncate is set.
  task automatic add_object(input bit truncate);
    int lvl;
    bit in_s;
    int n;
    int len;
    lvl  = 1;
    in_s = 1'b1;
    n    = 0;
    len  = $urandom_range(2, 30);
    frame_q.push_back(BYTE_OPEN);
    frame_q.push_back(BYTE_QUOTE);
    while (lvl > 0 && n < len) begin
      if (in_s) begin
        case ($urandom_range(9))
          0: begin
            // escape, followed by anything, quotes included
            frame_q.push_back(BYTE_BSLASH);
            frame_q.push_back(pick_byte());
          end
          1, 2: begin
            frame_q.push_back(BYTE_QUOTE);
            in_s = 1'b0;
          end
          3: frame_q.push_back(BYTE_OPEN);   // braces in strings do not count
          4: frame_q.push_back(BYTE_CLOSE);
          default: frame_q.push_back(8'h61 + 8'($urandom_range(25)));
        endcase
      end else begin
        case ($urandom_range(9))
          0, 1: begin
            frame_q.push_back(BYTE_OPEN);
            lvl++;
          end
          2, 3: begin
            frame_q.push_back(BYTE_CLOSE);
            lvl--;
          end
          4, 5: begin
            frame_q.push_back(BYTE_QUOTE);
            in_s = 1'b1;
          end
          6:       frame_q.push_back(":");
          7:       frame_q.push_back(",");
          default: frame_q.push_back(8'h30 + 8'($urandom_range(9)));
        endcase
      end
      n++;
    end
    if (!truncate && lvl > 0) begin
      if (in_s) frame_q.push_back(BYTE_QUOTE);
      repeat (lvl) frame_q.push_back(BYTE_CLOSE);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short buffers for the corner cases.
  task automatic test_directed_spans();
    // '{' plus quote at offset zero: rest of buffer ignored, ends not found
    push_text("{\"a{\"b\"}");
    send_frame();
    // escaped quote and brace inside a string, then bytes after the object
    push_text("x{\"\\\"}\"}{");
    frame_q.push_back(8'hFF);
    send_frame();
    // no object: extreme bytes, '{' not followed by a quote
    frame_q.push_back(8'h00);
    frame_q.push_back(BYTE_OPEN);
    frame_q.push_back(8'hFF);
    send_frame();
    // one-byte buffer
    frame_q.push_back(BYTE_CLOSE);
    send_frame();
    // '{' at zero without a quote, object opening at offset one
    push_text("{{\"\"}");
    send_frame();
  endtask

  // Drive the depth counter into saturation, then end the buffer.
  task automatic test_depth_saturation();
    push_text("a{\"k\"");
    repeat (int'(MAX_DEPTH) - 1) frame_q.push_back(BYTE_OPEN);
    frame_q.push_back(BYTE_OPEN);    // first brace past max depth: sets overflow
    frame_q.push_back(BYTE_OPEN);
    frame_q.push_back(BYTE_CLOSE);
    frame_q.push_back("z");
    send_frame();
  endtask

  // Mostly well-formed objects with random content, some cut short,
  // the rest noise.
  task automatic test_random_frames(input int unsigned count);
    int unsigned stop_at;
    int          kind;
    int          n;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        // empty prefix now and then puts the start at offset zero
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
        repeat (n) frame_q.push_back(pick_byte());
        add_object(kind >= 70);
        repeat ($urandom_range(0, 4)) frame_q.push_back(pick_byte());
      end else begin
        repeat ($urandom_range(1, 12)) frame_q.push_back(pick_byte());
      end
      send_frame();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clear_scan();
    send_idle_pct = 16;
    recv_idle_pct = 76;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_spans();
    test_random_frames(450);

    // swap the pressure: slow source, fast sink
    send_idle_pct = 76;
    recv_idle_pct = 16;
    test_random_frames(450);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_depth_saturation();
    test_random_frames(450);

    in_valid <= 1'b0;
    while (span_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
